/* design/rbsi_pkg.sv */
// Package: shared constants and control types for the ray/box slab intersect unit
package rbsi_pkg;

  // default coordinate width (Q16.16)
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS       = 16;
  localparam int NUM_AXES        = 3;
  localparam int NUM_LANES       = 2 * NUM_AXES;

  // reset value of each half extent (1.0 in Q16.16)
  localparam longint unsigned HALF_RESET_DEF = 65536;

  // configuration register indices
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Z = 2'd2;

  // hit counts
  localparam logic [1:0] HITS_NONE = 2'd0;
  localparam logic [1:0] HITS_ONE  = 2'd1;
  localparam logic [1:0] HITS_TWO  = 2'd2;

  // per-item control that rides alongside the divider lanes
  typedef struct packed {
    logic                 miss;   // a zero-direction axis with start outside its slab
    logic [NUM_AXES-1:0]  dzero;  // direction component is zero on that axis
    logic [NUM_LANES-1:0] qneg;   // quotient sign per lane
  } rbsi_side_t;

endpackage

/* design/rbsi_if.sv */
// Interfaces: ray input channel and hit result channel
interface rbsi_ray_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] start_x;
  logic [W-1:0] start_y;
  logic [W-1:0] start_z;
  logic [W-1:0] dir_x;
  logic [W-1:0] dir_y;
  logic [W-1:0] dir_z;

  modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rbsi_hit_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [1:0]   hit_count;
  logic [W-1:0] first_t;
  logic [W-1:0] second_t;

  modport source (output valid, hit_count, first_t, second_t, input ready);
  modport sink   (input valid, hit_count, first_t, second_t, output ready);
endinterface

/* design/rbsi_prep.sv */
// Front stage: plane distances, magnitudes and signs, zero-direction slab check
module rbsi_prep #(
  parameter int W = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [W-2:0]                half [rbsi_pkg::NUM_AXES],
  input  logic [W-1:0]                start [rbsi_pkg::NUM_AXES],
  input  logic [W-1:0]                dir [rbsi_pkg::NUM_AXES],
  output logic                        valid_r,
  output logic [W-1:0]                nmag_r [rbsi_pkg::NUM_LANES],
  output logic [W-1:0]                dmag_r [rbsi_pkg::NUM_LANES],
  output rbsi_pkg::rbsi_side_t        side_r
);
  import rbsi_pkg::*;

  logic [W:0]   n1 [NUM_AXES];
  logic [W:0]   n2 [NUM_AXES];
  logic [W-1:0] nmag_nxt [NUM_LANES];
  logic [W-1:0] dmag_nxt [NUM_LANES];
  rbsi_side_t   side_nxt;

  // distances to the +half and -half planes, W+1 bits signed
  always_comb begin
    side_nxt = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      n1[a] = {2'b00, half[a]} - {start[a][W-1], start[a]};
      n2[a] = (~{2'b00, half[a]} + (W+1)'(1)) - {start[a][W-1], start[a]};
      nmag_nxt[2*a]   = n1[a][W] ? W'(~n1[a] + (W+1)'(1)) : n1[a][W-1:0];
      nmag_nxt[2*a+1] = n2[a][W] ? W'(~n2[a] + (W+1)'(1)) : n2[a][W-1:0];
      dmag_nxt[2*a]   = dir[a][W-1] ? (~dir[a] + W'(1)) : dir[a];
      dmag_nxt[2*a+1] = dmag_nxt[2*a];
      side_nxt.qneg[2*a]   = n1[a][W] ^ dir[a][W-1];
      side_nxt.qneg[2*a+1] = n2[a][W] ^ dir[a][W-1];
      side_nxt.dzero[a]    = (dir[a] == '0);
      // both plane distances strictly of one sign: start lies outside the slab
      if (side_nxt.dzero[a] &&
          ((!n1[a][W] && n1[a] != '0 && !n2[a][W] && n2[a] != '0) ||
           (n1[a][W] && n2[a][W]))) begin
        side_nxt.miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nmag_r <= nmag_nxt;
      dmag_r <= dmag_nxt;
      side_r <= side_nxt;
    end
  end

endmodule

/* design/rbsi_div_pipe.sv */
// Pipelined restoring divider: six lanes of (n * 2^16) / d, one quotient bit per stage
module rbsi_div_pipe #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [W-1:0]          nmag [rbsi_pkg::NUM_LANES],
  input  logic [W-1:0]          dmag [rbsi_pkg::NUM_LANES],
  input  rbsi_pkg::rbsi_side_t  in_side,
  output logic                  out_valid,
  output logic [W-2:0]          quot [rbsi_pkg::NUM_LANES],
  output logic [rbsi_pkg::NUM_LANES-1:0] sat,
  output rbsi_pkg::rbsi_side_t  out_side
);
  import rbsi_pkg::*;

  localparam int NW = W + FRAC_BITS;          // shifted dividend width
  localparam int TW = NW - (W - 1);           // top bits checked for overflow
  localparam int CW = (TW > W) ? TW : W;      // compare width

  // stage k holds the partial result after quotient bit W-1-k
  logic             valid_r [W];
  rbsi_side_t       side_r  [W];
  logic [W-1:0]     rem_r   [W][NUM_LANES];
  logic [W-2:0]     low_r   [W][NUM_LANES];
  logic [W-1:0]     d_r     [W][NUM_LANES];
  logic [W-2:0]     q_r     [W][NUM_LANES];
  logic             sat_r   [W][NUM_LANES];

  // first stage: quotient of 2^(W-1) or more saturates
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_init
    logic [NW-1:0] num;
    logic [CW-1:0] top_x;
    logic [CW-1:0] d_x;
    assign num   = {nmag[l], {FRAC_BITS{1'b0}}};
    assign top_x = CW'(num[NW-1:W-1]);
    assign d_x   = CW'(dmag[l]);
    always_ff @(posedge clk) begin
      if (adv) begin
        sat_r[0][l] <= (top_x >= d_x);
        rem_r[0][l] <= top_x[W-1:0];
        low_r[0][l] <= num[W-2:0];
        d_r[0][l]   <= dmag[l];
        q_r[0][l]   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (adv) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
    end
  end

  // one restoring step per stage
  for (genvar k = 1; k < W; k++) begin : g_step
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [W:0] trial;
      logic       take;
      assign trial = {rem_r[k-1][l], low_r[k-1][l][W-1-k]};
      assign take  = (trial >= {1'b0, d_r[k-1][l]});
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k][l] <= take ? W'(trial - {1'b0, d_r[k-1][l]}) : trial[W-1:0];
          low_r[k][l] <= low_r[k-1][l];
          d_r[k][l]   <= d_r[k-1][l];
          sat_r[k][l] <= sat_r[k-1][l];
          q_r[k][l]   <= q_r[k-1][l] | ((W-1)'(take) << (W-1-k));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (adv) begin
        valid_r[k] <= valid_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = valid_r[W-1];
  assign out_side  = side_r[W-1];
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
    assign quot[l] = q_r[W-1][l];
    assign sat[l]  = sat_r[W-1][l];
  end

endmodule

/* design/rbsi_resolve.sv */
// Back end: signed parameters, slab bounds, entry/exit and the result register
module rbsi_resolve #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [W-2:0]          quot [rbsi_pkg::NUM_LANES],
  input  logic [rbsi_pkg::NUM_LANES-1:0] sat,
  input  rbsi_pkg::rbsi_side_t  in_side,
  output logic                  out_valid_r,
  output logic [1:0]            hit_count_r,
  output logic [W-1:0]          first_t_r,
  output logic [W-1:0]          second_t_r
);
  import rbsi_pkg::*;

  localparam logic [W-1:0] TMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] TMin = {1'b1, {(W-1){1'b0}}};

  // stage 1: signed, saturated parameters
  logic                 v1_r;
  logic                 miss1_r;
  logic [NUM_AXES-1:0]  dzero1_r;
  logic signed [W-1:0]  t_r [NUM_LANES];
  logic signed [W-1:0]  t_nxt [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (sat[l]) begin
        t_nxt[l] = in_side.qneg[l] ? TMin : TMax;
      end else begin
        t_nxt[l] = in_side.qneg[l] ? -$signed({1'b0, quot[l]}) : $signed({1'b0, quot[l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r      <= t_nxt;
      miss1_r  <= in_side.miss;
      dzero1_r <= in_side.dzero;
    end
  end

  // stage 2: per-axis lower and upper crossing; a flat direction places no bound
  logic                 v2_r;
  logic                 miss2_r;
  logic signed [W-1:0]  lo_r [NUM_AXES];
  logic signed [W-1:0]  hi_r [NUM_AXES];
  logic signed [W-1:0]  lo_nxt [NUM_AXES];
  logic signed [W-1:0]  hi_nxt [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (dzero1_r[a]) begin
        lo_nxt[a] = TMin;
        hi_nxt[a] = TMax;
      end else if (t_r[2*a] < t_r[2*a+1]) begin
        lo_nxt[a] = t_r[2*a];
        hi_nxt[a] = t_r[2*a+1];
      end else begin
        lo_nxt[a] = t_r[2*a+1];
        hi_nxt[a] = t_r[2*a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      miss2_r <= miss1_r;
    end
  end

  // stage 3: entry is the largest lower bound, exit the smallest upper bound
  logic                 v3_r;
  logic                 miss3_r;
  logic signed [W-1:0]  entry_r;
  logic signed [W-1:0]  exit_r;
  logic signed [W-1:0]  entry_nxt;
  logic signed [W-1:0]  exit_nxt;

  always_comb begin
    entry_nxt = lo_r[0];
    exit_nxt  = hi_r[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (lo_r[a] > entry_nxt) begin
        entry_nxt = lo_r[a];
      end
      if (hi_r[a] < exit_nxt) begin
        exit_nxt = hi_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      entry_r <= entry_nxt;
      exit_r  <= exit_nxt;
      miss3_r <= miss2_r;
    end
  end

  // result register: positive parameters in order
  logic [1:0]   hit_count_nxt;
  logic [W-1:0] first_t_nxt;
  logic [W-1:0] second_t_nxt;

  always_comb begin
    hit_count_nxt = HITS_NONE;
    first_t_nxt   = '0;
    second_t_nxt  = '0;
    if (!miss3_r && !(entry_r > exit_r)) begin
      if (entry_r > 0) begin
        hit_count_nxt = HITS_TWO;
        first_t_nxt   = entry_r;
        second_t_nxt  = exit_r;
      end else if (exit_r > 0) begin
        hit_count_nxt = HITS_ONE;
        first_t_nxt   = exit_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_count_r <= hit_count_nxt;
      first_t_r   <= first_t_nxt;
      second_t_r  <= second_t_nxt;
    end
  end

  // result consistency
  a_no_bad_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (hit_count_r != 2'd3))
    else $error("hit count out of range");

  a_two_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && hit_count_r == HITS_TWO) |->
      ($signed(first_t_r) > 0 && $signed(second_t_r) >= $signed(first_t_r)))
    else $error("two hits not positive and ordered");

  a_one_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && hit_count_r == HITS_ONE) |->
      ($signed(first_t_r) > 0 && second_t_r == '0))
    else $error("single hit malformed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && hit_count_r == HITS_NONE) |-> (first_t_r == '0 && second_t_r == '0))
    else $error("miss carries non-zero parameters");

endmodule

/* design/ray_box_slab_intersect_unit.sv */
// Top level: ray against origin-centred box slab test, fully pipelined
//
//  channel   direction  contents
//  in_ray    sink       start_x/y/z, dir_x/y/z (signed Q16.16)
//  out_hit   source     hit_count, first_t, second_t (signed Q16.16)
//  cfg_*     write      cfg_idx selects half_size_x/y/z, cfg_wdata the value
//
// One ray per cycle unless the result channel stalls; one front stage, COORD_WIDTH
// divider stages (saturation check, then a quotient bit each; six lanes side by side),
// three resolve stages and the result register.
// Reset clears all valid bits and loads the half extents with 1.0.
// A stall on the result channel freezes every stage at once; in_ray.ready follows it.
module ray_box_slab_intersect_unit #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rbsi_ray_if.sink                       in_ray,
  rbsi_hit_if.source                     out_hit,
  input  logic                           cfg_we,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [COORD_WIDTH-2:0]         cfg_wdata
);
  import rbsi_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam logic [W-2:0] HalfReset = (W-1)'(HALF_RESET_DEF);

  logic [W-2:0] half_r [NUM_AXES];
  logic [W-1:0] start  [NUM_AXES];
  logic [W-1:0] dir    [NUM_AXES];
  logic         adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r[0] <= HalfReset;
      half_r[1] <= HalfReset;
      half_r[2] <= HalfReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HALF_X: half_r[0] <= cfg_wdata;
        REG_HALF_Y: half_r[1] <= cfg_wdata;
        REG_HALF_Z: half_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the result register is empty or being taken
  assign adv          = !out_hit.valid || out_hit.ready;
  assign in_ray.ready = adv;

  assign start[0] = in_ray.start_x;
  assign start[1] = in_ray.start_y;
  assign start[2] = in_ray.start_z;
  assign dir[0]   = in_ray.dir_x;
  assign dir[1]   = in_ray.dir_y;
  assign dir[2]   = in_ray.dir_z;

  logic          p_valid;
  logic [W-1:0]  p_nmag [NUM_LANES];
  logic [W-1:0]  p_dmag [NUM_LANES];
  rbsi_side_t    p_side;

  rbsi_prep #(.W(W)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ray.valid),
    .half     (half_r),
    .start    (start),
    .dir      (dir),
    .valid_r  (p_valid),
    .nmag_r   (p_nmag),
    .dmag_r   (p_dmag),
    .side_r   (p_side)
  );

  logic                 d_valid;
  logic [W-2:0]         d_quot [NUM_LANES];
  logic [NUM_LANES-1:0] d_sat;
  rbsi_side_t           d_side;

  rbsi_div_pipe #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (p_valid),
    .nmag      (p_nmag),
    .dmag      (p_dmag),
    .in_side   (p_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .sat       (d_sat),
    .out_side  (d_side)
  );

  rbsi_resolve #(.W(W)) u_resolve (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (d_valid),
    .quot        (d_quot),
    .sat         (d_sat),
    .in_side     (d_side),
    .out_valid_r (out_hit.valid),
    .hit_count_r (out_hit.hit_count),
    .first_t_r   (out_hit.first_t),
    .second_t_r  (out_hit.second_t)
  );

endmodule
